FILE: rtl/nprc_pkg.sv
// shared types and constants for the nearest point and radius count block
package nprc_pkg;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 33;

    // squared cutoff distance for the nearest search
    localparam logic [DIST_W-1:0] FAR_SQ  = 33'd100000000;
    // start value of the running minimum carried with a query
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic KIND_NEAR  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    localparam logic [1:0] CMP_BELOW = 2'd0;
    localparam logic [1:0] CMP_EQUAL = 2'd1;
    localparam logic [1:0] CMP_ABOVE = 2'd2;

    // query traveling down the chain
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [DIST_W-1:0]   dmin;
    } t_flow;

    // count report shifted toward the head of the chain
    typedef struct packed {
        logic [15:0] hits;
        logic [1:0]  cmp;
    } t_rep;

endpackage

FILE: rtl/nprc_cell.sv
// one reference point cell: distance, radius count and report shift stage
module nprc_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_active,
    input  logic                 i_load,
    input  logic signed [15:0]   i_ld_x,
    input  logic signed [15:0]   i_ld_y,
    input  logic [15:0]          i_ld_reach,
    input  logic [15:0]          i_ld_limit,
    input  nprc_pkg::t_flow      i_flow,
    output nprc_pkg::t_flow      o_flow,
    output logic                 o_busy,
    input  logic                 i_capture,
    input  logic                 i_shift,
    input  nprc_pkg::t_rep       i_rep_next,
    output nprc_pkg::t_rep       o_rep
);

    logic signed [15:0]  r_ref_x;
    logic signed [15:0]  r_ref_y;
    logic [31:0]         r_reach_sq;
    logic [15:0]         r_limit;
    logic [15:0]         r_hits;
    nprc_pkg::t_flow     r_s1;
    nprc_pkg::t_flow     r_s2;
    nprc_pkg::t_flow     n_s2;
    logic [31:0]         r_dx_sq;
    logic [31:0]         r_dy_sq;
    nprc_pkg::t_rep      r_rep;

    logic [16:0]                  w_dx;
    logic [16:0]                  w_dy;
    logic [16:0]                  w_dx_neg;
    logic [16:0]                  w_dy_neg;
    logic [15:0]                  w_dx_abs;
    logic [15:0]                  w_dy_abs;
    logic [nprc_pkg::DIST_W-1:0]  w_sum;
    logic                         w_hit;
    logic [1:0]                   w_cmp;

    // table entry, radius squared taken once at load
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ref_x    <= i_ld_x;
            r_ref_y    <= i_ld_y;
            r_reach_sq <= {16'd0, i_ld_reach} * {16'd0, i_ld_reach};
            r_limit    <= i_ld_limit;
        end
    end

    // absolute coordinate differences
    always_comb begin
        w_dx     = {r_ref_x[15], r_ref_x} - {i_flow.x[15], i_flow.x};
        w_dy     = {r_ref_y[15], r_ref_y} - {i_flow.y[15], i_flow.y};
        w_dx_neg = 17'd0 - w_dx;
        w_dy_neg = 17'd0 - w_dy;
        w_dx_abs = w_dx[16] ? w_dx_neg[15:0] : w_dx[15:0];
        w_dy_abs = w_dy[16] ? w_dy_neg[15:0] : w_dy[15:0];
    end

    // stage one: squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1 <= i_flow;
        end
        r_dx_sq <= {16'd0, w_dx_abs} * {16'd0, w_dx_abs};
        r_dy_sq <= {16'd0, w_dy_abs} * {16'd0, w_dy_abs};
    end

    // stage two: sum, running minimum and radius test
    always_comb begin
        w_sum = {1'b0, r_dx_sq} + {1'b0, r_dy_sq};
        w_hit = i_active && r_s1.valid && (w_sum <= {9'd0, r_reach_sq[31:8]});
        n_s2  = r_s1;
        if (i_active && (w_sum < r_s1.dmin)) begin
            n_s2.dmin = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    // saturating hit counter, cleared when the batch is reported
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits <= 16'd0;
        end else if (i_capture) begin
            r_hits <= 16'd0;
        end else if (w_hit && (r_hits != 16'hFFFF)) begin
            r_hits <= r_hits + 16'd1;
        end
    end

    // count against capacity
    always_comb begin
        if (r_hits < r_limit) begin
            w_cmp = nprc_pkg::CMP_BELOW;
        end else if (r_hits == r_limit) begin
            w_cmp = nprc_pkg::CMP_EQUAL;
        end else begin
            w_cmp = nprc_pkg::CMP_ABOVE;
        end
    end

    // report copy, shifts one cell toward the head per count beat
    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_rep.hits <= r_hits;
            r_rep.cmp  <= w_cmp;
        end else if (i_shift) begin
            r_rep <= i_rep_next;
        end
    end

    assign o_flow = r_s2;
    assign o_busy = r_s1.valid | r_s2.valid;
    assign o_rep  = r_rep;

endmodule

FILE: rtl/nearest_point_and_radius_count.sv
// top level: nearest query search and per point radius counting over a chain of cells
//
// Each reference point lives in its own cell; a query walks the chain with two register
// stages per cell (squares, then sum and compare), so a query can be accepted every cycle
// while no final query is pending. A load beat is taken only once the chain has drained
// after the last query. After the query marked final, the input stalls until that query
// has left the chain and the report beats have gone out: one nearest report, then one
// count report per point in use, shifted out of the chain one per beat.
// Configuration writes are always taken.
module nearest_point_and_radius_count #(
    parameter int REF_POINTS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [3:0]          i_cfg_points_in_use,
    // input items
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_op,
    input  logic [2:0]          i_entry_index,
    input  logic signed [15:0]  i_pos_x,
    input  logic signed [15:0]  i_pos_y,
    input  logic [15:0]         i_reach,
    input  logic [15:0]         i_limit,
    input  logic                i_final_query,
    // result items
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_kind,
    output logic [2:0]          o_report_index,
    output logic signed [15:0]  o_near_x,
    output logic signed [15:0]  o_near_y,
    output logic                o_found,
    output logic [15:0]         o_hits,
    output logic [1:0]          o_versus_limit,
    output logic                o_run_end
);

    localparam int MAX_ACT = (REF_POINTS < 8) ? REF_POINTS : 8;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_NEAR  = 2'd1;
    localparam logic [1:0] ST_COUNT = 2'd2;

    logic [3:0]                   r_points_in_use;
    logic [1:0]                   r_state;
    logic [2:0]                   r_k;
    logic                         r_final_pend;
    logic [nprc_pkg::DIST_W-1:0]  r_best_sq;
    logic [15:0]                  r_best_x;
    logic [15:0]                  r_best_y;
    logic                         r_have;

    nprc_pkg::t_flow              w_head;
    nprc_pkg::t_flow              w_flow [REF_POINTS+1];
    nprc_pkg::t_rep               w_rep  [REF_POINTS+1];
    logic [REF_POINTS-1:0]        w_busy;
    logic [3:0]                   w_n;
    logic                         w_in_acc;
    logic                         w_out_acc;
    logic                         w_capture;
    logic                         w_shift;
    logic                         w_last_count;
    nprc_pkg::t_flow              w_end;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_in_use <= 4'd0;
        end else if (i_cfg_valid) begin
            r_points_in_use <= i_cfg_points_in_use;
        end
    end

    assign w_n = (int'(r_points_in_use) > MAX_ACT) ? 4'(MAX_ACT) : r_points_in_use;

    // input handshake: loads wait for an empty chain
    assign o_in_ready = (r_state == ST_RUN) && !r_final_pend
                        && ((i_op == nprc_pkg::OP_QUERY) || !(|w_busy));
    assign w_in_acc   = i_in_valid && o_in_ready;

    // query entering the chain
    always_comb begin
        w_head.valid = w_in_acc && (i_op == nprc_pkg::OP_QUERY);
        w_head.last  = i_final_query;
        w_head.x     = i_pos_x;
        w_head.y     = i_pos_y;
        w_head.dmin  = nprc_pkg::DIST_MAX;
    end

    assign w_flow[0]         = w_head;
    assign w_rep[REF_POINTS] = '0;

    // the chain of cells
    for (genvar g = 0; g < REF_POINTS; g++) begin : g_cell
        nprc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_active   (int'(w_n) > g),
            .i_load     (w_in_acc && (i_op == nprc_pkg::OP_LOAD)
                         && (int'(i_entry_index) == g)),
            .i_ld_x     (i_pos_x),
            .i_ld_y     (i_pos_y),
            .i_ld_reach (i_reach),
            .i_ld_limit (i_limit),
            .i_flow     (w_flow[g]),
            .o_flow     (w_flow[g+1]),
            .o_busy     (w_busy[g]),
            .i_capture  (w_capture),
            .i_shift    (w_shift),
            .i_rep_next (w_rep[g+1]),
            .o_rep      (w_rep[g])
        );
    end

    assign w_end        = w_flow[REF_POINTS];
    assign w_capture    = w_end.valid && w_end.last;
    assign w_out_acc    = o_out_valid && i_out_ready;
    assign w_shift      = (r_state == ST_COUNT) && w_out_acc;
    assign w_last_count = ({1'b0, r_k} + 4'd1) == w_n;

    // nearest query over the batch, first one wins ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_sq <= nprc_pkg::FAR_SQ;
            r_best_x  <= 16'd0;
            r_best_y  <= 16'd0;
            r_have    <= 1'b0;
        end else if ((r_state == ST_NEAR) && w_out_acc) begin
            r_best_sq <= nprc_pkg::FAR_SQ;
            r_best_x  <= 16'd0;
            r_best_y  <= 16'd0;
            r_have    <= 1'b0;
        end else if (w_end.valid && (w_end.dmin < r_best_sq)) begin
            r_best_sq <= w_end.dmin;
            r_best_x  <= w_end.x;
            r_best_y  <= w_end.y;
            r_have    <= 1'b1;
        end
    end

    // report sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_RUN;
            r_k          <= 3'd0;
            r_final_pend <= 1'b0;
        end else begin
            case (r_state)
                ST_RUN: begin
                    if (w_in_acc && (i_op == nprc_pkg::OP_QUERY) && i_final_query) begin
                        r_final_pend <= 1'b1;
                    end
                    if (w_capture) begin
                        r_state <= ST_NEAR;
                    end
                end
                ST_NEAR: begin
                    if (w_out_acc) begin
                        r_k <= 3'd0;
                        if (w_n == 4'd0) begin
                            r_state      <= ST_RUN;
                            r_final_pend <= 1'b0;
                        end else begin
                            r_state <= ST_COUNT;
                        end
                    end
                end
                ST_COUNT: begin
                    if (w_out_acc) begin
                        if (w_last_count) begin
                            r_state      <= ST_RUN;
                            r_final_pend <= 1'b0;
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    // result fields
    always_comb begin
        o_out_valid    = 1'b0;
        o_kind         = nprc_pkg::KIND_NEAR;
        o_report_index = 3'd0;
        o_near_x       = 16'sd0;
        o_near_y       = 16'sd0;
        o_found        = 1'b0;
        o_hits         = 16'd0;
        o_versus_limit = nprc_pkg::CMP_BELOW;
        o_run_end      = 1'b0;
        case (r_state)
            ST_NEAR: begin
                o_out_valid = 1'b1;
                o_near_x    = r_best_x;
                o_near_y    = r_best_y;
                o_found     = r_have;
                o_run_end   = (w_n == 4'd0);
            end
            ST_COUNT: begin
                o_out_valid    = 1'b1;
                o_kind         = nprc_pkg::KIND_COUNT;
                o_report_index = r_k;
                o_hits         = w_rep[0].hits;
                o_versus_limit = w_rep[0].cmp;
                o_run_end      = w_last_count;
            end
            default: begin
                o_out_valid = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/nprc_checker.sv
// port level checks for the nearest point and radius count block, bound to the top level
module nprc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_kind,
    input logic [2:0]         o_report_index,
    input logic signed [15:0] o_near_x,
    input logic signed [15:0] o_near_y,
    input logic               o_found,
    input logic               o_run_end
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_report_index) && $stable(o_run_end))
        else $error("result beat changed while stalled");

    // no input beat is taken while reports are going out
    a_no_in_while_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken during report");

    // the batch ends with the run end beat
    a_end_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_run_end |=> !o_out_valid)
        else $error("report after run end");

    // count reports step through the entries in order
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && (o_kind == nprc_pkg::KIND_COUNT) && !o_run_end
        |=> o_out_valid && (o_kind == nprc_pkg::KIND_COUNT)
            && (o_report_index == 3'($past(o_report_index) + 3'd1)))
        else $error("count reports out of order");

    // nothing found means a zero point
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == nprc_pkg::KIND_NEAR) && !o_found
        |-> (o_near_x == 16'sd0) && (o_near_y == 16'sd0))
        else $error("nearest point set without a find");

endmodule

bind nearest_point_and_radius_count nprc_checker u_nprc_checker (.*);

FILE: sim/tb_nearest_point_and_radius_count.sv
// testbench for the nearest point and radius count block, checked against a local predictor
module tb_nearest_point_and_radius_count;

    localparam int NPTS        = 8;
    localparam int DRAIN       = 2 * NPTS + 12;
    localparam int RANDOM_BEATS = 188;
    localparam longint FAR_DIST = 10000;

    // one input beat as the sender sees it
    typedef struct {
        logic               op;
        logic [2:0]         entry;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [15:0]        reach;
        logic [15:0]        cap;
        logic               last_q;
    } t_beat;

    // one report beat as the block should emit it
    typedef struct packed {
        logic               kind;
        logic [2:0]         idx;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic               found;
        logic [15:0]        hits;
        logic [1:0]         vs;
        logic               run_end;
    } t_report;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_points_in_use;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_op;
    logic [2:0]         i_entry_index;
    logic signed [15:0] i_pos_x;
    logic signed [15:0] i_pos_y;
    logic [15:0]        i_reach;
    logic [15:0]        i_limit;
    logic               i_final_query;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_kind;
    logic [2:0]         o_report_index;
    logic signed [15:0] o_near_x;
    logic signed [15:0] o_near_y;
    logic               o_found;
    logic [15:0]        o_hits;
    logic [1:0]         o_versus_limit;
    logic               o_run_end;

    // predictor state: table, per point counts and the running nearest query
    logic signed [15:0] ref_x     [NPTS];
    logic signed [15:0] ref_y     [NPTS];
    logic [15:0]        ref_reach [NPTS];
    logic [15:0]        ref_cap   [NPTS];
    logic [15:0]        hit_cnt   [NPTS];
    longint             best_dsq;
    logic signed [15:0] best_x;
    logic signed [15:0] best_y;
    bit                 have_best;
    logic [3:0]         pts_reg;
    t_report            awaited_reports[$];

    int error_count   = 0;
    int beats_sent    = 0;
    int reports_seen  = 0;
    int batches_done  = 0;
    int cfg_writes    = 0;
    int idle_pct      = 25;
    int hold_cycles   = 0;

    nearest_point_and_radius_count #(
        .REF_POINTS(NPTS)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_points_in_use (i_cfg_points_in_use),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_op                (i_op),
        .i_entry_index       (i_entry_index),
        .i_pos_x             (i_pos_x),
        .i_pos_y             (i_pos_y),
        .i_reach             (i_reach),
        .i_limit             (i_limit),
        .i_final_query       (i_final_query),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_kind              (o_kind),
        .o_report_index      (o_report_index),
        .o_near_x            (o_near_x),
        .o_near_y            (o_near_y),
        .o_found             (o_found),
        .o_hits              (o_hits),
        .o_versus_limit      (o_versus_limit),
        .o_run_end           (o_run_end)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(99) >= idle_pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic void clear_batch();
        foreach (hit_cnt[i]) hit_cnt[i] = '0;
        best_dsq  = FAR_DIST * FAR_DIST;
        best_x    = '0;
        best_y    = '0;
        have_best = 1'b0;
    endfunction

    function automatic void reset_search();
        foreach (ref_x[i]) begin
            ref_x[i]     = '0;
            ref_y[i]     = '0;
            ref_reach[i] = '0;
            ref_cap[i]   = '0;
        end
        pts_reg = '0;
        clear_batch();
    endfunction

    // apply one accepted beat and queue the reports that a final query releases
    function automatic void update_search_and_counts(t_beat b);
        int      n;
        longint  dx, dy, dsq, rr;
        t_report r;
        if (b.op == nprc_pkg::OP_LOAD) begin
            if (b.entry < NPTS) begin
                ref_x[b.entry]     = b.px;
                ref_y[b.entry]     = b.py;
                ref_reach[b.entry] = b.reach;
                ref_cap[b.entry]   = b.cap;
            end
            return;
        end
        n = (pts_reg > NPTS) ? NPTS : int'(pts_reg);
        for (int i = 0; i < n; i++) begin
            dx  = longint'(ref_x[i]) - longint'(b.px);
            dy  = longint'(ref_y[i]) - longint'(b.py);
            dsq = dx * dx + dy * dy;
            rr  = longint'(ref_reach[i]) * longint'(ref_reach[i]);
            if (dsq < best_dsq) begin
                best_dsq  = dsq;
                best_x    = b.px;
                best_y    = b.py;
                have_best = 1'b1;
            end
            if (dsq * 256 <= rr && hit_cnt[i] != 16'hFFFF) hit_cnt[i]++;
        end
        if (!b.last_q) return;
        // nearest report first, then one count report per point in use
        r = '0;
        r.kind = nprc_pkg::KIND_NEAR;
        if (have_best) begin
            r.nx    = best_x;
            r.ny    = best_y;
            r.found = 1'b1;
        end
        r.run_end = (n == 0);
        awaited_reports.push_back(r);
        for (int i = 0; i < n; i++) begin
            r = '0;
            r.kind = nprc_pkg::KIND_COUNT;
            r.idx  = 3'(i);
            r.hits = hit_cnt[i];
            if (hit_cnt[i] < ref_cap[i])       r.vs = nprc_pkg::CMP_BELOW;
            else if (hit_cnt[i] == ref_cap[i]) r.vs = nprc_pkg::CMP_EQUAL;
            else                               r.vs = nprc_pkg::CMP_ABOVE;
            r.run_end = (i == n - 1);
            awaited_reports.push_back(r);
        end
        batches_done++;
        clear_batch();
    endfunction

    function automatic t_beat load_beat(int e, int x, int y, int reach, int cap, bit last_q);
        t_beat b;
        b.op     = nprc_pkg::OP_LOAD;
        b.entry  = 3'(e);
        b.px     = 16'(x);
        b.py     = 16'(y);
        b.reach  = 16'(reach);
        b.cap    = 16'(cap);
        b.last_q = last_q;
        return b;
    endfunction

    function automatic t_beat query_beat(int x, int y, bit last_q);
        t_beat b;
        b.op     = nprc_pkg::OP_QUERY;
        b.entry  = 3'($urandom_range(7));
        b.px     = 16'(x);
        b.py     = 16'(y);
        b.reach  = 16'($urandom_range(16'hFFFF));
        b.cap    = 16'($urandom_range(16'hFFFF));
        b.last_q = last_q;
        return b;
    endfunction

    // offer one beat and hold it until the block takes it
    task automatic send_beat(input t_beat b);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= b.op;
        i_entry_index <= b.entry;
        i_pos_x       <= b.px;
        i_pos_y       <= b.py;
        i_reach       <= b.reach;
        i_limit       <= b.cap;
        i_final_query <= b.last_q;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        update_search_and_counts(b);
        beats_sent++;
    endtask

    task automatic drop_input_valid();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // wait for the block to go idle, then write the point count
    task automatic write_points(input logic [3:0] v);
        drop_input_valid();
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_points_in_use <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        pts_reg = v;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, plus a long hold when a test asks for one
    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    function automatic void check_field(string name, longint want_v, longint got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            error_count++;
        end
    endfunction

    // compare each report beat with the oldest one waiting
    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            reports_seen++;
            if (awaited_reports.size() == 0) begin
                $error("unexpected report beat: kind %0d index %0d", o_kind, o_report_index);
                error_count++;
            end else begin
                want = awaited_reports.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("report_index", want.idx, o_report_index);
                check_field("near_x", $signed(want.nx), $signed(o_near_x));
                check_field("near_y", $signed(want.ny), $signed(o_near_y));
                check_field("found", want.found, o_found);
                check_field("hits", want.hits, o_hits);
                check_field("versus_limit", want.vs, o_versus_limit);
                check_field("run_end", want.run_end, o_run_end);
            end
        end
    end

    // no points in use right after reset: only the nearest report comes out
    task automatic test_empty_batch();
        send_beat(query_beat(123, -45, 1'b0));
        send_beat(query_beat(-32768, 32767, 1'b1));
    endtask

    // fill the whole table with extreme coordinates, radii and capacities
    task automatic test_table_load();
        send_beat(load_beat(0, 0, 0, 16'hFFFF, 0, 1'b0));
        send_beat(load_beat(1, -32768, -32768, 0, 16'hFFFF, 1'b0));
        send_beat(load_beat(2, 32767, 32767, 16 * 100, 1, 1'b0));
        send_beat(load_beat(3, 1000, -1000, 16 * 50, 2, 1'b0));
        // final mark on a load must be ignored
        send_beat(load_beat(4, -5000, 2500, 16 * 4000, 3, 1'b1));
        send_beat(load_beat(5, 200, 200, 16 * 3, 1, 1'b0));
        send_beat(load_beat(6, -32768, 32767, 16, 0, 1'b0));
        send_beat(load_beat(7, 32767, -32768, 16 * 2000, 5, 1'b0));
    endtask

    // ties, radius boundary, exact cutoff distance and corners, with the count clamped
    task automatic test_directed_queries();
        write_points(4'd15);
        // equal distances: the first query keeps the nearest slot
        send_beat(query_beat(1003, -996, 1'b0));
        send_beat(query_beat(996, -1003, 1'b1));
        // on the radius edge, just outside it, then dead on a point
        send_beat(query_beat(203, 200, 1'b0));
        send_beat(query_beat(200, 204, 1'b0));
        send_beat(query_beat(1000, -1000, 1'b1));
        // exactly the cutoff distance away: nothing found
        send_beat(query_beat(32767, 22767, 1'b1));
        // one step inside the cutoff, and the far corner
        send_beat(query_beat(32767, 22768, 1'b0));
        send_beat(query_beat(-32768, -32768, 1'b1));
    endtask

    // long receiver hold while batches keep coming, so the input backs up
    task automatic test_back_pressure();
        int keep_idle;
        keep_idle = idle_pct;
        write_points(4'd8);
        send_beat(load_beat(0, 0, 0, 16'hFFFF, 4, 1'b0));
        drop_input_valid();
        idle_pct    = 0;
        hold_cycles = 400;
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 4; i++)
                send_beat(query_beat($urandom_range(0, 400) - 200,
                                     $urandom_range(0, 400) - 200, i == 3));
        idle_pct = keep_idle;
    endtask

    function automatic t_beat random_load();
        int e, x, y, reach, cap;
        e = $urandom_range(NPTS - 1);
        if ($urandom_range(4) == 0) begin
            x = $urandom_range(16'hFFFF);
            y = $urandom_range(16'hFFFF);
        end else begin
            x = $urandom_range(0, 4000) - 2000;
            y = $urandom_range(0, 4000) - 2000;
        end
        reach = ($urandom_range(4) == 0) ? $urandom_range(16'hFFFF)
                                         : $urandom_range(0, 16 * 600);
        cap   = ($urandom_range(4) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(0, 6);
        return load_beat(e, x, y, reach, cap, $urandom_range(1));
    endfunction

    // query near some table point, now and then anywhere
    function automatic t_beat random_query(bit last_q);
        int e;
        if ($urandom_range(9) == 0)
            return query_beat($urandom_range(16'hFFFF), $urandom_range(16'hFFFF), last_q);
        e = $urandom_range(NPTS - 1);
        return query_beat(int'(ref_x[e]) + $urandom_range(0, 600) - 300,
                          int'(ref_y[e]) + $urandom_range(0, 600) - 300, last_q);
    endfunction

    // random phases: a point count, then batches of loads and queries ending in a final query
    task automatic test_random_batches();
        logic [3:0] forced_pts [4];
        int         phase, nq, sent_here;
        forced_pts = '{4'd0, 4'd15, 4'd1, 4'd8};
        sent_here  = 0;
        phase      = 0;
        while (sent_here < RANDOM_BEATS) begin
            write_points(phase < 4 ? forced_pts[phase] : 4'($urandom_range(15)));
            case ($urandom_range(3))
                0:       idle_pct = 0;
                1:       idle_pct = 60;
                default: idle_pct = 25;
            endcase
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 3)) begin
                    send_beat(random_load());
                    sent_here++;
                end
                nq = $urandom_range(2, 12);
                for (int i = 0; i < nq; i++) begin
                    // an occasional load in the middle of a batch
                    if ($urandom_range(11) == 0) begin
                        send_beat(random_load());
                        sent_here++;
                    end
                    send_beat(random_query(i == nq - 1));
                    sent_here++;
                end
            end
            phase++;
        end
        idle_pct = 25;
    endtask

    // run sequence
    initial begin
        i_rst_n             = 1'b0;
        i_cfg_valid         = 1'b0;
        i_cfg_points_in_use = '0;
        i_in_valid          = 1'b0;
        i_op                = nprc_pkg::OP_LOAD;
        i_entry_index       = '0;
        i_pos_x             = '0;
        i_pos_y             = '0;
        i_reach             = '0;
        i_limit             = '0;
        i_final_query       = 1'b0;
        reset_search();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_batch();
        test_table_load();
        test_directed_queries();
        test_back_pressure();
        test_random_batches();

        drop_input_valid();
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("run covered %0d input beats in %0d batches, %0d report beats checked",
                 beats_sent, batches_done, reports_seen);
        $display("point count written %0d times, a long output hold included", cfg_writes);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("timeout with %0d report beats still awaited", awaited_reports.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
rtl/nprc_pkg.sv
rtl/nprc_cell.sv
rtl/nearest_point_and_radius_count.sv
rtl/nprc_checker.sv
sim/tb_nearest_point_and_radius_count.sv
